/* rtl/jets_pkg.sv */
// Shared types, constants and helpers for the Julia escape-time pixel core.
// Holds the fixed-point formats, register codes, multiplier cell bus and saturation.
// No dependencies.
package jets_pkg;

    // Fixed-point format: signed Q4.28 values, Q8.56 products.
    localparam int Q_BITS     = 32;
    localparam int FRAC_BITS  = 28;
    localparam int STEP_BITS  = 31;
    localparam int COORD_BITS = 12;

    localparam int MAX_ITERATIONS = 255;
    localparam int CNT_BITS       = $clog2(MAX_ITERATIONS + 1);
    localparam int COLOR_BITS     = 8;

    localparam int S_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 3 * COLOR_BITS;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_STEP   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_ORIGIN = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_C_REAL   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_C_IMAG   = 3'd5;

    // Reset view: [-0.05, 0.05] on both axes at 800x800, c = -0.7269 + 0.1889i.
    localparam logic signed [Q_BITS-1:0] X_ORIGIN_RST = -32'sd13421773;
    localparam logic [STEP_BITS-1:0]     X_STEP_RST   = 31'd33554;
    localparam logic signed [Q_BITS-1:0] Y_ORIGIN_RST = -32'sd13421773;
    localparam logic [STEP_BITS-1:0]     Y_STEP_RST   = 31'd33554;
    localparam logic signed [Q_BITS-1:0] C_REAL_RST   = -32'sd195125733;
    localparam logic signed [Q_BITS-1:0] C_IMAG_RST   = 32'sd50707458;

    localparam logic signed [Q_BITS-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_BITS-1:0] Q_MIN = 32'sh8000_0000;

    // Multiplier chain: each cell retires one radix-256 digit of the multiplier.
    localparam int MUL_BITS   = 32;
    localparam int DIGIT_BITS = 8;
    localparam int ACC_BITS   = MUL_BITS + DIGIT_BITS;
    localparam int CELLS      = MUL_BITS / DIGIT_BITS;
    localparam int PROD_BITS  = 2 * MUL_BITS;
    localparam int LANES      = 3;

    localparam int LANE_X  = 0;
    localparam int LANE_Y  = 1;
    localparam int LANE_XY = 2;

    // Start point sum and update widths.
    localparam int START_PROD_BITS = STEP_BITS + COORD_BITS;
    localparam int SAT_BITS        = START_PROD_BITS + 2;
    localparam int RE_BITS         = Q_BITS + FRAC_BITS;
    localparam int SUM_SQ_BITS     = PROD_BITS + 1;

    // 4.0 in Q8.56.
    localparam logic [SUM_SQ_BITS-1:0] ESCAPE_LIMIT = SUM_SQ_BITS'(1) << (2 * FRAC_BITS + 2);

    typedef struct packed {
        logic                           valid;
        logic [LANES-1:0][MUL_BITS-1:0] a;
        logic [LANES-1:0][MUL_BITS-1:0] b;
        logic [LANES-1:0][MUL_BITS-1:0] hi;
        logic [LANES-1:0][MUL_BITS-1:0] lo;
    } cell_bus_t;

    // Clamp a wide signed value to the Q4.28 range.
    function automatic logic signed [Q_BITS-1:0] sat_q(input logic signed [SAT_BITS-1:0] v);
        logic signed [Q_BITS-1:0] r;
        if (!v[SAT_BITS-1] && (|v[SAT_BITS-2:Q_BITS-1])) begin
            r = Q_MAX;
        end else if (v[SAT_BITS-1] && !(&v[SAT_BITS-2:Q_BITS-1])) begin
            r = Q_MIN;
        end else begin
            r = v[Q_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/julia_escape_time_pixel_core.sv */
// Top level of the Julia escape-time pixel core: configuration, iteration control,
// output register and the chain of multiplier cells. Depends on jets_pkg, jets_mul_cell.

// Each input beat carries one pixel (column, row). The core maps it to the complex
// plane as origin plus step times coordinate, saturated to signed Q4.28, then runs
// z = z^2 + c until |z|^2 reaches 4.0 or 255 iterations have been made, and sends one
// output beat: (count, 0, 0) for an escaped point, white (255, 255, 255) otherwise.
// All products go through one chain of four multiplier cells; each cell retires
// eight bits of the multiplier per cycle for three products side by side. One pixel
// is worked on at a time: the start point makes one pass through the chain, then
// each iteration makes one more, 1 to 255 per pixel, and a finishing step loads the
// output register. Each iteration has a launch step, the pass through the four
// cells, after the last of which the escape test is registered, and a step that
// registers the new z. A new pixel is taken as soon as the previous one sits in
// the output register, even while that result still waits for the consumer.
// Configuration registers may be written only while no pixel is in flight; there
// is no read-back and writes to unused indexes are dropped. Reset is synchronous
// and active low; no clearing pass is needed.
module julia_escape_time_pixel_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [jets_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [jets_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // Pixel input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [jets_pkg::S_TDATA_BITS-1:0]    s_tdata,  // pixel_col, pixel_row
    // Colour output stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [jets_pkg::M_TDATA_BITS-1:0]    m_tdata   // red, green, blue
);
    import jets_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_RUN,
        ST_ITER_LAUNCH,
        ST_ITER_RUN,
        ST_ITER_UPDATE,
        ST_FINISH
    } state_t;

    // Configuration registers.
    logic signed [Q_BITS-1:0] x_origin_reg, y_origin_reg, c_real_reg, c_imag_reg;
    logic [STEP_BITS-1:0]     x_step_reg, y_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg <= X_ORIGIN_RST;
            x_step_reg   <= X_STEP_RST;
            y_origin_reg <= Y_ORIGIN_RST;
            y_step_reg   <= Y_STEP_RST;
            c_real_reg   <= C_REAL_RST;
            c_imag_reg   <= C_IMAG_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_X_ORIGIN: x_origin_reg <= cfg_wdata[Q_BITS-1:0];
                REG_X_STEP:   x_step_reg   <= cfg_wdata[STEP_BITS-1:0];
                REG_Y_ORIGIN: y_origin_reg <= cfg_wdata[Q_BITS-1:0];
                REG_Y_STEP:   y_step_reg   <= cfg_wdata[STEP_BITS-1:0];
                REG_C_REAL:   c_real_reg   <= cfg_wdata[Q_BITS-1:0];
                REG_C_IMAG:   c_imag_reg   <= cfg_wdata[Q_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Control and data registers.
    state_t                      state_reg, state_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0]     m_tdata_reg, m_tdata_next;
    logic signed [Q_BITS-1:0]    zx_reg, zx_next, zy_reg, zy_next;
    logic [CNT_BITS-1:0]         count_reg, count_next;
    logic signed [RE_BITS-1:0]   re_reg, re_next, im_reg, im_next;
    logic                        esc_reg, esc_next;

    // Multiplier chain. Slot zero is the launch bus; slot CELLS is the chain output.
    cell_bus_t                   launch_bus;
    cell_bus_t                   chain_bus [CELLS+1];
    logic [CELLS-1:0]            cell_valid;

    assign chain_bus[0] = launch_bus;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        jets_mul_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .in_bus  (chain_bus[g]),
            .out_bus (chain_bus[g+1])
        );
        assign cell_valid[g] = chain_bus[g+1].valid;
    end

    // The chain multiplies magnitudes; the sign of zx*zy is restored afterwards.
    logic [MUL_BITS-1:0] zx_mag, zy_mag;
    assign zx_mag = zx_reg[Q_BITS-1] ? MUL_BITS'(-zx_reg) : MUL_BITS'(zx_reg);
    assign zy_mag = zy_reg[Q_BITS-1] ? MUL_BITS'(-zy_reg) : MUL_BITS'(zy_reg);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        launch_bus       = '0;
        launch_bus.valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // The start point products step*coordinate use the X and Y lanes.
                launch_bus.valid     = s_tvalid;
                launch_bus.a[LANE_X] = MUL_BITS'(x_step_reg);
                launch_bus.b[LANE_X] = MUL_BITS'(s_tdata[COORD_BITS-1:0]);
                launch_bus.a[LANE_Y] = MUL_BITS'(y_step_reg);
                launch_bus.b[LANE_Y] = MUL_BITS'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
            end
            ST_ITER_LAUNCH: begin
                launch_bus.valid      = 1'b1;
                launch_bus.a[LANE_X]  = zx_mag;
                launch_bus.b[LANE_X]  = zx_mag;
                launch_bus.a[LANE_Y]  = zy_mag;
                launch_bus.b[LANE_Y]  = zy_mag;
                launch_bus.a[LANE_XY] = zx_mag;
                launch_bus.b[LANE_XY] = zy_mag;
            end
            default: ;
        endcase
    end

    // Full-width products at the end of the chain.
    logic [PROD_BITS-1:0] prod_x, prod_y, prod_xy;
    assign prod_x  = {chain_bus[CELLS].hi[LANE_X],  chain_bus[CELLS].lo[LANE_X]};
    assign prod_y  = {chain_bus[CELLS].hi[LANE_Y],  chain_bus[CELLS].lo[LANE_Y]};
    assign prod_xy = {chain_bus[CELLS].hi[LANE_XY], chain_bus[CELLS].lo[LANE_XY]};

    // Start point: origin + step*coordinate, exact, then clamped.
    logic signed [SAT_BITS-1:0] start_x, start_y;
    assign start_x = SAT_BITS'(x_origin_reg) + $signed({2'b00, prod_x[START_PROD_BITS-1:0]});
    assign start_y = SAT_BITS'(y_origin_reg) + $signed({2'b00, prod_y[START_PROD_BITS-1:0]});

    // Escape test on the exact Q8.56 sum of squares. The differences below are only
    // used when the point has not escaped, where both squares stay under 2^58 and
    // the narrow signed forms are exact.
    logic [SUM_SQ_BITS-1:0]    sum_sq;
    logic signed [RE_BITS-1:0] re_calc, twice_xy;
    assign sum_sq   = {1'b0, prod_x} + {1'b0, prod_y};
    assign re_calc  = $signed(RE_BITS'(prod_x) - RE_BITS'(prod_y));
    assign twice_xy = $signed({prod_xy[RE_BITS-2:0], 1'b0});

    // Update: floor to Q4.28 by dropping fraction bits, add c, clamp.
    logic signed [SAT_BITS-1:0] upd_x, upd_y;
    assign upd_x = SAT_BITS'($signed(re_reg[RE_BITS-1:FRAC_BITS])) + SAT_BITS'(c_real_reg);
    assign upd_y = SAT_BITS'($signed(im_reg[RE_BITS-1:FRAC_BITS])) + SAT_BITS'(c_imag_reg);

    logic [CNT_BITS-1:0] count_inc;
    assign count_inc = count_reg + CNT_BITS'(1);

    // Colour from the final count: white when the limit was reached.
    logic                   at_limit;
    logic [COLOR_BITS-1:0]  red_val, gb_val;
    assign at_limit = (count_reg == CNT_BITS'(MAX_ITERATIONS));
    assign red_val  = at_limit ? {COLOR_BITS{1'b1}} : COLOR_BITS'(count_reg);
    assign gb_val   = at_limit ? {COLOR_BITS{1'b1}} : '0;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        zx_next       = zx_reg;
        zy_next       = zy_reg;
        count_next    = count_reg;
        re_next       = re_reg;
        im_next       = im_reg;
        esc_next      = esc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_START_RUN;
                end
            end
            ST_START_RUN: begin
                if (chain_bus[CELLS].valid) begin
                    zx_next    = sat_q(start_x);
                    zy_next    = sat_q(start_y);
                    count_next = '0;
                    state_next = ST_ITER_LAUNCH;
                end
            end
            ST_ITER_LAUNCH: begin
                state_next = ST_ITER_RUN;
            end
            ST_ITER_RUN: begin
                if (chain_bus[CELLS].valid) begin
                    esc_next   = (sum_sq >= ESCAPE_LIMIT);
                    re_next    = re_calc;
                    im_next    = (zx_reg[Q_BITS-1] ^ zy_reg[Q_BITS-1]) ? -twice_xy : twice_xy;
                    state_next = ST_ITER_UPDATE;
                end
            end
            ST_ITER_UPDATE: begin
                if (esc_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    zx_next    = sat_q(upd_x);
                    zy_next    = sat_q(upd_y);
                    count_next = count_inc;
                    if (count_inc == CNT_BITS'(MAX_ITERATIONS)) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_ITER_LAUNCH;
                    end
                end
            end
            ST_FINISH: begin
                // Wait until the output register is free or being emptied.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {gb_val, gb_val, red_val};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        count_reg <= count_next;
        re_reg    <= re_next;
        im_reg    <= im_next;
        esc_reg   <= esc_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Products only come out of the chain while the controller waits for them.
    a_chain_out_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_bus[CELLS].valid |-> (state_reg == ST_START_RUN || state_reg == ST_ITER_RUN))
        else $error("multiplier chain produced a result the controller did not wait for");

    // A new launch never overlaps products still in the chain.
    a_launch_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        launch_bus.valid |-> (cell_valid == '0))
        else $error("launch into a multiplier chain that is still busy");

    // The iteration limit is never passed.
    a_count_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ITER_UPDATE |-> count_reg != CNT_BITS'(MAX_ITERATIONS))
        else $error("iteration count reached the limit before an update");

    // A result beat appears only out of the finishing step.
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_FINISH)
        else $error("output beat raised outside the finishing step");

endmodule

/* rtl/jets_mul_cell.sv */
// One cell of the shift-and-add multiplier chain, three lanes wide.
// Depends on jets_pkg for the cell bus type and digit widths.
module jets_mul_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  jets_pkg::cell_bus_t in_bus,
    output jets_pkg::cell_bus_t out_bus
);
    import jets_pkg::*;

    logic                           valid_reg;
    logic [LANES-1:0][MUL_BITS-1:0] a_reg, b_reg, hi_reg, lo_reg;
    logic [LANES-1:0][MUL_BITS-1:0] a_next, b_next, hi_next, lo_next;
    logic [LANES-1:0][ACC_BITS-1:0] sum;

    // Add one digit's partial product to the running high word, then retire the
    // lowest byte of the sum into the low word and move to the next digit.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sum[l]     = ACC_BITS'(in_bus.hi[l])
                       + ACC_BITS'(in_bus.a[l]) * ACC_BITS'(in_bus.b[l][DIGIT_BITS-1:0]);
            a_next[l]  = in_bus.a[l];
            b_next[l]  = {DIGIT_BITS'(0), in_bus.b[l][MUL_BITS-1:DIGIT_BITS]};
            hi_next[l] = sum[l][ACC_BITS-1:DIGIT_BITS];
            lo_next[l] = {sum[l][DIGIT_BITS-1:0], in_bus.lo[l][MUL_BITS-1:DIGIT_BITS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_bus.valid;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign out_bus.valid = valid_reg;
    assign out_bus.a     = a_reg;
    assign out_bus.b     = b_reg;
    assign out_bus.hi    = hi_reg;
    assign out_bus.lo    = lo_reg;

endmodule
